>>> sv/gpe_pkg.sv
package gpe_pkg;

    // Input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_TABLE = 2'd2;

    // Operation codes carried through the queue
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_TABLE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_SOLID_BG     = 2'd1;
    localparam logic [1:0] REG_FRONT_COLOR  = 2'd2;
    localparam logic [1:0] REG_BACK_COLOR   = 2'd3;

    // Color table
    localparam int TABLE_DEPTH = 16;
    localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);

    // Bit select masks (one-bit and four-bit modes), last pixel index within a byte
    localparam logic [7:0] SEL_1BPP = 8'h80;
    localparam logic [7:0] SEL_4BPP = 8'hF0;
    localparam logic [2:0] LAST_IDX_1BPP = 3'd7;
    localparam logic [2:0] LAST_IDX_4BPP = 3'd1;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Payload layout: start {x, y, width, rows}; data {.., byte}; table {.., index, color}
    localparam int PAYLOAD_W = 48;

    typedef struct packed {
        logic [1:0]           op;
        logic [PAYLOAD_W-1:0] data;
    } gpe_entry_t;

endpackage

>>> sv/gpe_front.sv
module gpe_front
    import gpe_pkg::*;
(
    input  logic              in_valid,
    input  logic [1:0]        command,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic [7:0]        glyph_width,
    input  logic [7:0]        glyph_height,
    input  logic [7:0]        bitmap_byte,
    input  logic [3:0]        table_index,
    input  logic [15:0]       table_color,
    output logic              push,
    output gpe_entry_t        entry
);

    logic [7:0] rows;

    // Zero width means an empty glyph: no rows to draw
    assign rows = (glyph_width == 8'd0) ? 8'd0 : glyph_height;

    // Classify the command and pack its payload
    always_comb
    begin
        entry      = '0;
        push       = 1'b0;
        case (command)
            CMD_START:
            begin
                push       = in_valid;
                entry.op   = OP_START;
                entry.data = {origin_x, origin_y, glyph_width, rows};
            end
            CMD_DATA:
            begin
                push       = in_valid;
                entry.op   = OP_DATA;
                entry.data = {{(PAYLOAD_W-8){1'b0}}, bitmap_byte};
            end
            CMD_TABLE:
            begin
                push       = in_valid;
                entry.op   = OP_TABLE;
                entry.data = {{(PAYLOAD_W-20){1'b0}}, table_index, table_color};
            end
            default:
            begin
                // unknown command: transfer is taken and dropped
                push       = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/gpe_queue.sv
module gpe_queue
    import gpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  gpe_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output gpe_entry_t head
);

    gpe_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // A lone push grows the count by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    // A lone pop shrinks the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

>>> sv/gpe_back.sv
module gpe_back
    import gpe_pkg::*;
#(
    parameter int COLOR_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               head_valid,
    input  gpe_entry_t         head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic [15:0]        pixel_color,
    output logic               draw,
    output logic               last_pixel
);

    // Configuration registers
    logic                  pixel_format_reg;
    logic                  solid_bg_reg;
    logic [COLOR_BITS-1:0] front_color_reg;
    logic [COLOR_BITS-1:0] back_color_reg;

    // Glyph walk state
    logic [15:0] left_col_reg, left_col_next;
    logic [15:0] row_reg, row_next;
    logic [7:0]  col_cnt_reg, col_cnt_next;
    logic [7:0]  rows_left_reg, rows_left_next;
    logic [7:0]  width_reg, width_next;
    logic [2:0]  pix_idx_reg, pix_idx_next;

    logic [COLOR_BITS-1:0] color_table [TABLE_DEPTH];

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] pixel_x_reg;
    logic signed [15:0] pixel_y_reg;
    logic [15:0]        pixel_color_reg;
    logic               draw_reg;
    logic               last_reg;

    logic                   out_free;
    logic                   is_data;
    logic                   glyph_active;
    logic                   emit;
    logic [7:0]             byte_val;
    logic [TABLE_IDX_W-1:0] pix_val;
    logic [COLOR_BITS-1:0]  table_rd;
    logic [COLOR_BITS-1:0]  pix_color;
    logic                   pix_draw;
    logic                   col_end;
    logic                   glyph_end;
    logic                   byte_end;
    logic [8:0]             col_plus;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= 1'b0;
            solid_bg_reg     <= 1'b1;
            front_color_reg  <= COLOR_BITS'(16'hFFFF);
            back_color_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[0];
                REG_SOLID_BG:     solid_bg_reg     <= cfg_data[0];
                REG_FRONT_COLOR:  front_color_reg  <= COLOR_BITS'(cfg_data);
                REG_BACK_COLOR:   back_color_reg   <= COLOR_BITS'(cfg_data);
                default:          ;
            endcase
        end
    end

    // Pixel extraction from the head byte, MSB first
    assign byte_val = head.data[7:0];
    always_comb
    begin
        if (pixel_format_reg)
        begin
            pix_val = pix_idx_reg[0] ? byte_val[3:0] : byte_val[7:4];
        end
        else
        begin
            pix_val = {{(TABLE_IDX_W-1){1'b0}}, byte_val[~pix_idx_reg]};
        end
    end

    // Color selection; in four-bit mode with a solid background a zero value reads table entry zero
    assign table_rd = color_table[pix_val];
    always_comb
    begin
        pix_color = '0;
        pix_draw  = 1'b0;
        if (pix_val != '0)
        begin
            pix_color = pixel_format_reg ? table_rd : front_color_reg;
            pix_draw  = 1'b1;
        end
        else if (solid_bg_reg)
        begin
            pix_color = pixel_format_reg ? table_rd : back_color_reg;
            pix_draw  = 1'b1;
        end
    end

    // Row and glyph end detection
    assign col_plus     = {1'b0, col_cnt_reg} + 9'd1;
    assign col_end      = (col_plus >= {1'b0, width_reg});
    assign glyph_end    = (rows_left_reg == 8'd1) && col_end;
    assign byte_end     = (pix_idx_reg == (pixel_format_reg ? LAST_IDX_4BPP : LAST_IDX_1BPP));
    assign glyph_active = (rows_left_reg != 8'd0);

    // Issue control
    assign out_free = !out_valid_reg || !out_stall;
    assign is_data  = head_valid && (head.op == OP_DATA);
    assign emit     = is_data && glyph_active && out_free;
    assign pop      = head_valid
                   && ((head.op != OP_DATA) || !glyph_active
                       || (emit && (byte_end || glyph_end)));

    // Walk state next values
    always_comb
    begin
        left_col_next  = left_col_reg;
        row_next       = row_reg;
        col_cnt_next   = col_cnt_reg;
        rows_left_next = rows_left_reg;
        width_next     = width_reg;
        pix_idx_next   = pix_idx_reg;
        if (emit)
        begin
            if (col_end)
            begin
                col_cnt_next   = 8'd0;
                row_next       = row_reg + 16'd1;
                rows_left_next = rows_left_reg - 8'd1;
            end
            else
            begin
                col_cnt_next = col_plus[7:0];
            end
            pix_idx_next = pix_idx_reg + 3'd1;
        end
        else if (head_valid && (head.op == OP_START))
        begin
            left_col_next  = head.data[47:32];
            row_next       = head.data[31:16];
            width_next     = head.data[15:8];
            rows_left_next = head.data[7:0];
            col_cnt_next   = 8'd0;
        end
        if (pop)
        begin
            pix_idx_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_col_reg  <= '0;
            row_reg       <= '0;
            col_cnt_reg   <= '0;
            rows_left_reg <= '0;
            width_reg     <= '0;
            pix_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_col_reg  <= left_col_next;
            row_reg       <= row_next;
            col_cnt_reg   <= col_cnt_next;
            rows_left_reg <= rows_left_next;
            width_reg     <= width_next;
            pix_idx_reg   <= pix_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Color table writes
    always_ff @(posedge clk)
    begin
        if (head_valid && (head.op == OP_TABLE))
        begin
            color_table[head.data[19:16]] <= COLOR_BITS'(head.data[15:0]);
        end
    end

    // Output register
    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg     <= left_col_reg + {8'd0, col_cnt_reg};
            pixel_y_reg     <= row_reg;
            pixel_color_reg <= 16'(pix_color);
            draw_reg        <= pix_draw;
            last_reg        <= glyph_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign draw        = draw_reg;
    assign last_pixel  = last_reg;

    // A new pixel only comes from a data byte at the queue head
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(head_valid && (head.op == OP_DATA)))
        else $error("pixel issued without a data byte");

    // Issuing the final pixel closes the glyph
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && glyph_end) |=> (rows_left_reg == 8'd0))
        else $error("glyph still active after last pixel");

    // Within a byte the pixel index steps by one
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !pop) |=> (pix_idx_reg == $past(pix_idx_reg) + 3'd1))
        else $error("pixel index did not advance");

    // A byte is retired whenever its final pixel is issued
    a_byte_retire: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && byte_end) |-> pop)
        else $error("data byte not retired at its end");

endmodule

>>> sv/glyph_pixel_expander_unit.sv
// A data byte transfer into an empty queue is written into the command queue, then its
// first pixel is registered into the pixel output register, from which it can transfer out.
// Throughput: one pixel per cycle while out_stall is low, up to eight pixels per byte in
// one-bit mode and two in four-bit mode; start, table write and ignored bytes retire
// without pixels. The single-entry pixel output register sets this rate; a 4-entry
// command queue sits ahead of it. Reset (rst_n, async low) resets config, glyph state
// and queue; the color table is not cleared.
module glyph_pixel_expander_unit
    import gpe_pkg::*;
#(
    parameter int COLOR_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic [7:0]         glyph_width,
    input  logic [7:0]         glyph_height,
    input  logic [7:0]         bitmap_byte,
    input  logic [3:0]         table_index,
    input  logic [15:0]        table_color,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic [15:0]        pixel_color,
    output logic               draw,
    output logic               last_pixel
);

    logic       push;
    gpe_entry_t push_entry;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    gpe_entry_t head;

    assign in_stall = queue_full;

    // Command classification
    gpe_front u_front (
        .in_valid     (in_valid),
        .command      (command),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .bitmap_byte  (bitmap_byte),
        .table_index  (table_index),
        .table_color  (table_color),
        .push         (push),
        .entry        (push_entry)
    );

    // Command queue
    gpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Pixel expansion
    gpe_back #(
        .COLOR_BITS (COLOR_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .draw        (draw),
        .last_pixel  (last_pixel)
    );

endmodule

>>> dv/tb_glyph_pixel_expander_unit.sv
module tb_glyph_pixel_expander_unit;
    import gpe_pkg::*;

    // No package name exists for the spare command code
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int RUN_LIMIT = 4 * 500000;

    // One command transfer into the block
    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [7:0]  bits;
        logic [3:0]  tidx;
        logic [15:0] tcol;
    } glyph_cmd_t;

    // One expected pixel
    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] color;
        logic        draw;
        logic        last;
    } pixel_rec_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic [7:0]         bitmap_byte;
    logic [3:0]         table_index;
    logic [15:0]        table_color;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [15:0]        pixel_color;
    logic               draw;
    logic               last_pixel;

    glyph_pixel_expander_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .bitmap_byte  (bitmap_byte),
        .table_index  (table_index),
        .table_color  (table_color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .draw         (draw),
        .last_pixel   (last_pixel)
    );

    // Predictor copy of configuration
    logic        fmt_4bpp = 1'b0;
    logic        solid_bg = 1'b1;
    logic [15:0] front_col = 16'hFFFF;
    logic [15:0] back_col = 16'h0000;

    // Predictor copy of glyph walk state
    logic [15:0] left_col = '0;
    logic [15:0] row_y = '0;
    logic [7:0]  col_cnt = '0;
    logic [7:0]  rows_rem = '0;
    logic [7:0]  width_q = '0;
    logic [15:0] palette [TABLE_DEPTH];

    pixel_rec_t pending_pixels[$];
    pixel_rec_t want_px;

    // Idling knobs and counters
    int send_idle_pct = 0;
    int stall_pct = 0;
    int stall_hold = 0;
    int mismatch_count = 0;
    int pixels_checked = 0;
    int starts_sent = 0;
    int bytes_sent = 0;
    int table_sent = 0;
    int other_sent = 0;
    int in_stall_cycles = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout: %0d pixels still pending", pending_pixels.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output stall: a long hold when requested, random otherwise
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_hold > 0)
            begin
                out_stall <= 1'b1;
                stall_hold = stall_hold - 1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Compare each pixel transfer against the oldest pending pixel
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("pixel with none pending, x", pixel_x, 16'h0000);
            else
            begin
                want_px = pending_pixels.pop_front();
                pixels_checked++;
                if (pixel_x !== want_px.x)
                    report_mismatch("pixel_x", pixel_x, want_px.x);
                if (pixel_y !== want_px.y)
                    report_mismatch("pixel_y", pixel_y, want_px.y);
                if (pixel_color !== want_px.color)
                    report_mismatch("pixel_color", pixel_color, want_px.color);
                if (draw !== want_px.draw)
                    report_mismatch("draw", {15'b0, draw}, {15'b0, want_px.draw});
                if (last_pixel !== want_px.last)
                    report_mismatch("last_pixel", {15'b0, last_pixel}, {15'b0, want_px.last});
            end
        end
    end

    // Update glyph state and queue the pixels one accepted command yields
    function automatic void predict_pixels(glyph_cmd_t it);
        int         n_slots;
        logic [3:0] val;
        pixel_rec_t px;
        case (it.cmd)
            CMD_START:
            begin
                left_col = it.ox;
                row_y = it.oy;
                col_cnt = '0;
                width_q = it.w;
                rows_rem = (it.w == 8'd0) ? 8'd0 : it.h;
            end
            CMD_TABLE:
                palette[it.tidx] = it.tcol;
            CMD_DATA:
            begin
                n_slots = fmt_4bpp ? 2 : 8;
                for (int k = 0; k < n_slots && rows_rem != 8'd0; k++)
                begin
                    if (fmt_4bpp)
                        val = (k == 0) ? it.bits[7:4] : it.bits[3:0];
                    else
                        val = {3'b000, it.bits[7-k]};
                    px.x = left_col + {8'h00, col_cnt};
                    px.y = row_y;
                    px.color = '0;
                    px.draw = 1'b0;
                    if (val != 4'd0)
                    begin
                        px.color = fmt_4bpp ? palette[val] : front_col;
                        px.draw = 1'b1;
                    end
                    else if (solid_bg)
                    begin
                        px.color = fmt_4bpp ? palette[0] : back_col;
                        px.draw = 1'b1;
                    end
                    px.last = (rows_rem == 8'd1) && ({1'b0, col_cnt} + 9'd1 >= {1'b0, width_q});
                    pending_pixels.push_back(px);
                    col_cnt = col_cnt + 8'd1;
                    if (col_cnt >= width_q)
                    begin
                        col_cnt = '0;
                        row_y = row_y + 16'd1;
                        rows_rem = rows_rem - 8'd1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one command, wait for the transfer, then predict
    task automatic send_item(input glyph_cmd_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= it.cmd;
        origin_x <= it.ox;
        origin_y <= it.oy;
        glyph_width <= it.w;
        glyph_height <= it.h;
        bitmap_byte <= it.bits;
        table_index <= it.tidx;
        table_color <= it.tcol;
        do
        begin
            @(posedge clk);
            if (in_stall)
                in_stall_cycles++;
        end
        while (in_stall);
        predict_pixels(it);
        case (it.cmd)
            CMD_START: starts_sent++;
            CMD_DATA:  bytes_sent++;
            CMD_TABLE: table_sent++;
            default:   other_sent++;
        endcase
    endtask

    // Unused fields carry random noise
    function automatic glyph_cmd_t noisy_cmd(input logic [1:0] cmd);
        glyph_cmd_t it;
        it.cmd = cmd;
        it.ox = 16'($urandom);
        it.oy = 16'($urandom);
        it.w = 8'($urandom);
        it.h = 8'($urandom);
        it.bits = 8'($urandom);
        it.tidx = 4'($urandom);
        it.tcol = 16'($urandom);
        return it;
    endfunction

    task automatic send_start(input logic [15:0] x, input logic [15:0] y,
                              input logic [7:0] w, input logic [7:0] h);
        glyph_cmd_t it;
        it = noisy_cmd(CMD_START);
        it.ox = x;
        it.oy = y;
        it.w = w;
        it.h = h;
        send_item(it);
    endtask

    task automatic send_data(input logic [7:0] bits);
        glyph_cmd_t it;
        it = noisy_cmd(CMD_DATA);
        it.bits = bits;
        send_item(it);
    endtask

    task automatic send_table(input logic [3:0] idx, input logic [15:0] color);
        glyph_cmd_t it;
        it = noisy_cmd(CMD_TABLE);
        it.tidx = idx;
        it.tcol = color;
        send_item(it);
    endtask

    // Drop valid, wait for all pending pixels, then let queued commands retire
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PIXEL_FORMAT: fmt_4bpp = value[0];
            REG_SOLID_BG:     solid_bg = value[0];
            REG_FRONT_COLOR:  front_col = value;
            REG_BACK_COLOR:   back_col = value;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic fmt, input logic solid,
                                input logic [15:0] front, input logic [15:0] back);
        settle();
        write_reg(REG_PIXEL_FORMAT, {15'b0, fmt});
        write_reg(REG_SOLID_BG, {15'b0, solid});
        write_reg(REG_FRONT_COLOR, front);
        write_reg(REG_BACK_COLOR, back);
    endtask

    // Fill every palette entry before any four-bit pixel can read one
    task automatic test_table_load();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == 1)
                send_table(i[3:0], 16'hFFFF);
            else if (i == 2)
                send_table(i[3:0], 16'h0000);
            else
                send_table(i[3:0], 16'($urandom));
        end
    endtask

    // One-bit mode corner cases
    task automatic test_directed_1bpp();
        glyph_cmd_t it;
        apply_config(1'b0, 1'b1, 16'hA5C3, 16'h3C5A);
        send_data(8'hFF);                          // no glyph active
        it = noisy_cmd(CMD_UNUSED);
        send_item(it);                             // unknown command
        send_start(16'h0010, 16'h0020, 8'd0, 8'd5);
        send_data(8'hFF);                          // zero width: nothing
        send_start(16'h0010, 16'h0020, 8'd4, 8'd0);
        send_data(8'hFF);                          // zero height: nothing
        // x and y wrap; two bits left over after the last pixel
        send_start(16'h7FFE, 16'hFFFF, 8'd3, 8'd2);
        send_data(8'hA5);
        send_data(8'hFF);                          // after the glyph: ignored
        // largest glyph, then abandoned by a restart
        send_start(16'h8000, 16'h7FFF, 8'd255, 8'd255);
        send_data(8'h00);
        send_data(8'hFF);
        send_start(16'h0000, 16'h0000, 8'd1, 8'd3);
        send_data(8'h80);
        apply_config(1'b0, 1'b0, 16'h0000, 16'hFFFF);
        send_start(16'hFFFF, 16'h0000, 8'd8, 8'd1);
        send_data(8'h5A);                          // transparent zeros
    endtask

    // Four-bit mode: palette lookups, transparency, leftover nibble
    task automatic test_directed_4bpp();
        apply_config(1'b1, 1'b1, 16'h1234, 16'h4321);
        send_start(16'h0100, 16'h0200, 8'd3, 8'd1);
        send_data(8'h0F);
        send_data(8'hE1);                          // low nibble past the end
        apply_config(1'b1, 1'b0, 16'h1234, 16'h4321);
        send_start(16'hFFFE, 16'h8000, 8'd2, 8'd2);
        send_data(8'h10);
        send_data(8'h0F);
    endtask

    // Random glyph sequences with a little noise
    task automatic run_glyph_traffic(input int n_items);
        int         sent;
        int         pick;
        int         need;
        int         extra;
        glyph_cmd_t it;
        logic [7:0] w;
        logic [7:0] h;
        sent = 0;
        while (sent < n_items)
        begin
            pick = int'($urandom_range(99));
            if (pick < 6)
            begin
                it = noisy_cmd(($urandom_range(1) != 0) ? CMD_UNUSED : CMD_DATA);
                send_item(it);
            end
            else if (pick < 14)
            begin
                send_table(4'($urandom), 16'($urandom));
                sent++;
            end
            else
            begin
                pick = int'($urandom_range(99));
                if (pick < 85)
                begin
                    w = 8'($urandom_range(1, 10));
                    h = 8'($urandom_range(1, 5));
                end
                else if (pick < 93)
                begin
                    w = 8'($urandom_range(0, 255));
                    h = 8'($urandom_range(0, 255));
                end
                else
                begin
                    w = 8'($urandom_range(128, 255));
                    h = 8'd1;
                end
                send_start(16'($urandom), 16'($urandom), w, h);
                sent++;
                need = (w == 0 || h == 0) ? 0 :
                       (int'(w) * int'(h) + (fmt_4bpp ? 1 : 7)) / (fmt_4bpp ? 2 : 8);
                extra = 0;
                pick = int'($urandom_range(99));
                if (need > 12)
                    need = int'($urandom_range(1, 12));  // abandoned by the next start
                else if (pick < 10 && need > 1)
                    need = need - int'($urandom_range(1, need - 1));
                else if (pick < 20)
                    extra = int'($urandom_range(1, 3));
                for (int i = 0; i < need + extra; i++)
                begin
                    send_data(8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        apply_config(1'b0, 1'b1, 16'($urandom), 16'($urandom));
        send_idle_pct = 0;  stall_pct = 0;
        run_glyph_traffic(52);
        apply_config(1'b1, 1'b0, 16'($urandom), 16'($urandom));
        send_idle_pct = 71; stall_pct = 0;
        run_glyph_traffic(52);
        apply_config(1'b0, 1'b0, 16'h0000, 16'hFFFF);
        send_idle_pct = 0;  stall_pct = 71;
        run_glyph_traffic(52);
        apply_config(1'b1, 1'b1, 16'($urandom), 16'($urandom));
        send_idle_pct = 30; stall_pct = 30;
        run_glyph_traffic(52);
        apply_config(1'b1, 1'b1, 16'hFFFF, 16'h0000);
        send_idle_pct = 0;  stall_pct = 0;
        run_glyph_traffic(52);
        apply_config(1'b0, 1'b1, 16'hFFFF, 16'h0000);
        send_idle_pct = 30; stall_pct = 30;
        run_glyph_traffic(52);
    endtask

    // Hold the output off long enough for the command queue to fill
    task automatic test_backpressure();
        apply_config(1'b0, 1'b1, 16'($urandom), 16'($urandom));
        send_idle_pct = 0;
        stall_pct = 0;
        @(posedge clk);
        stall_hold = 300;
        send_start(16'($urandom), 16'($urandom), 8'd200, 8'd1);
        for (int i = 0; i < 25; i++)
            send_data(8'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PIXEL_FORMAT;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_START;
        origin_x = '0;
        origin_y = '0;
        glyph_width = '0;
        glyph_height = '0;
        bitmap_byte = '0;
        table_index = '0;
        table_color = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            palette[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_load();
        test_directed_1bpp();
        test_directed_4bpp();
        test_random_traffic();
        test_backpressure();
        settle();

        $display("covered %0d starts, %0d glyph bytes, %0d palette writes, %0d ignored commands",
                 starts_sent, bytes_sent, table_sent, other_sent);
        $display("checked %0d pixels in both formats; input held off for %0d cycles",
                 pixels_checked, in_stall_cycles);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
sv/gpe_pkg.sv
sv/gpe_front.sv
sv/gpe_queue.sv
sv/gpe_back.sv
sv/glyph_pixel_expander_unit.sv
dv/tb_glyph_pixel_expander_unit.sv
